// File: src/grj_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package grj_pkg;

   localparam int Q_W     = 32;
   localparam int WID_W   = 31;
   localparam int RATIO_W = 22;
   localparam int SQ_W    = 21;
   localparam int E_W     = 17;
   localparam int ARG_W   = 20;
   localparam int CSR_W   = 2;

   typedef enum logic [CSR_W-1:0] {
      REG_PEAK_HEIGHT = 2'd0,
      REG_PEAK_CENTER = 2'd1,
      REG_PEAK_WIDTH  = 2'd2,
      REG_BASELINE    = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [Q_W-1:0] measured;
      logic           far;
      logic           d_neg;
      logic           final_flag;
   } side_ratio_type;

   typedef struct packed {
      logic [RATIO_W-1:0] ratio;
      logic [SQ_W-1:0]    sq;
      logic [Q_W-1:0]     measured;
      logic               d_neg;
      logic               final_flag;
   } side_exp_type;

   typedef struct packed {
      logic [Q_W-1:0] residual;
      logic [E_W-1:0] e;
      logic           d_neg;
      logic           ov_c;
      logic           final_flag;
   } side_div_type;

endpackage

`default_nettype wire

// File: src/grj_div.sv
`timescale 1ns / 1ps
`default_nettype none

module grj_div #(
   parameter int QW = 22,
   parameter int DW = 31,
   parameter int SW = 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire logic          in_valid,
   input  wire logic [DW-1:0] in_rem,
   input  wire logic [QW-1:0] in_num,
   input  wire logic [DW-1:0] divisor,
   input  wire logic [SW-1:0] in_side,
   output logic               out_valid,
   output logic [QW-1:0]      out_quot,
   output logic [SW-1:0]      out_side
);

   logic          val_ff  [QW];
   logic [DW-1:0] rem_ff  [QW];
   logic [QW-1:0] nq_ff   [QW];
   logic [SW-1:0] side_ff [QW];

   for (genvar s = 0; s < QW; s++) begin : g_stage
      logic          val_in;
      logic [DW-1:0] rem_in;
      logic [QW-1:0] nq_in;
      logic [SW-1:0] side_in;
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          take;

      if (s == 0) begin : g_first
         assign val_in  = in_valid;
         assign rem_in  = in_rem;
         assign nq_in   = in_num;
         assign side_in = in_side;
      end else begin : g_next
         assign val_in  = val_ff[s-1];
         assign rem_in  = rem_ff[s-1];
         assign nq_in   = nq_ff[s-1];
         assign side_in = side_ff[s-1];
      end

      assign trial = {rem_in, nq_in[QW-1]};
      assign take  = trial >= {1'b0, divisor};
      assign diff  = trial - {1'b0, divisor};

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[s] <= 1'b0;
         end else if (en) begin
            val_ff[s] <= val_in;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= take ? diff[DW-1:0] : trial[DW-1:0];
            nq_ff[s]   <= {nq_in[QW-2:0], take};
            side_ff[s] <= side_in;
         end
      end
   end

   assign out_valid = val_ff[QW-1];
   assign out_quot  = nq_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

`default_nettype wire

// File: src/grj_exp.sv
`timescale 1ns / 1ps
`default_nettype none

module grj_exp #(
   parameter int EXP_TABLE_BITS = 8,
   parameter int SW = 1
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire logic                      in_valid,
   input  wire logic                      in_zero,
   input  wire logic [grj_pkg::ARG_W-1:0] in_arg,
   input  wire logic [SW-1:0]             in_side,
   output logic                           out_valid,
   output logic [grj_pkg::E_W-1:0]        out_e,
   output logic [SW-1:0]                  out_side
);

   localparam int TAB_N = 1 << EXP_TABLE_BITS;
   localparam int FB    = grj_pkg::ARG_W - EXP_TABLE_BITS;
   localparam int EW    = grj_pkg::E_W;

   typedef logic [EW-1:0] rom_type [TAB_N+1];

   function automatic longint unsigned udiv_u64(input longint unsigned num,
                                                input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      int              b;
      quo = '0;
      rem = '0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic rom_type build_rom();
      rom_type             rom;
      longint unsigned     y31;
      longint unsigned     term;
      longint unsigned     q32;
      longint unsigned     t32;
      longint              sum;
      int                  i;
      y31  = 64'd1 << (35 - EXP_TABLE_BITS);
      term = 64'd1 << 31;
      sum  = 64'sd1 <<< 31;
      for (i = 1; i <= 24; i++) begin
         term = udiv_u64((term * y31) >> 31, 64'(i));
         if (i % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      q32 = longint'(unsigned'(sum)) << 1;
      t32 = 64'd1 << 32;
      for (i = 0; i <= TAB_N; i++) begin
         rom[i] = EW'((t32 + 64'd32768) >> 16);
         t32    = (t32 * q32 + 64'h8000_0000) >> 32;
      end
      return rom;
   endfunction

   localparam rom_type EXP_ROM = build_rom();

   logic [EXP_TABLE_BITS-1:0] k;
   logic [EXP_TABLE_BITS:0]   k_next;
   logic                      val1_ff;
   logic                      zero1_ff;
   logic [EW-1:0]             hi_ff;
   logic [EW-1:0]             lo_ff;
   logic [FB-1:0]             frac_ff;
   logic [SW-1:0]             side1_ff;
   logic [EW-1:0]             diff;
   logic [EW+FB:0]            step;
   logic [EW-1:0]             e_in;
   logic                      val2_ff;
   logic [EW-1:0]             e_ff;
   logic [SW-1:0]             side2_ff;

   assign k      = in_arg[grj_pkg::ARG_W-1:FB];
   assign k_next = {1'b0, k} + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         val1_ff <= 1'b0;
         val2_ff <= 1'b0;
      end else if (en) begin
         val1_ff <= in_valid;
         val2_ff <= val1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zero1_ff <= in_zero;
         hi_ff    <= EXP_ROM[{1'b0, k}];
         lo_ff    <= EXP_ROM[k_next];
         frac_ff  <= in_arg[FB-1:0];
         side1_ff <= in_side;
         e_ff     <= e_in;
         side2_ff <= side1_ff;
      end
   end

   always_comb begin
      diff = (hi_ff >= lo_ff) ? (hi_ff - lo_ff) : '0;
      step = ({1'b0, diff} * {{EW{1'b0}}, frac_ff}) + ((EW+FB+1)'(1) << (FB - 1));
      e_in = zero1_ff ? '0 : (hi_ff - EW'(step >> FB));
   end

   assign out_valid = val2_ff;
   assign out_e     = e_ff;
   assign out_side  = side2_ff;

endmodule

`default_nettype wire

// File: src/gaussian_residual_jacobian.sv
`timescale 1ns / 1ps
`default_nettype none

// Evaluates a Gaussian peak model on a stream of samples and returns, per sample, the
// residual (model minus measured, plus a penalty of -10*height when height is not
// positive) and the derivatives by center and width in saturated signed Q16.16, with
// the derivative by height in unsigned Q1.16. One sample is taken per clock unless
// the result side stalls. Restoring dividers give the position-to-width ratio 22
// quotient bits and each of the two derivatives 32, one bit per stage. The whole
// pipeline advances only when the result register can move, so a stall at the result
// side stalls the input side in the same cycle. The user must write peak parameters
// via the csr port only while no sample is in flight; the block does not enforce it.
module gaussian_residual_jacobian #(
   parameter int EXP_TABLE_BITS = 8
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic [grj_pkg::CSR_W-1:0] csr_index,
   input  wire logic [grj_pkg::Q_W-1:0]   csr_wdata,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic signed [31:0]        req_position,
   input  wire logic signed [31:0]        req_measured,
   input  wire logic                      req_final_flag,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic signed [31:0]             rsp_residual,
   output logic [16:0]                    rsp_d_height,
   output logic signed [31:0]             rsp_d_center,
   output logic signed [31:0]             rsp_d_width,
   output logic                           rsp_final_out
);

   localparam int QW_OUT = grj_pkg::Q_W;
   localparam int RW     = grj_pkg::RATIO_W;
   localparam int WW     = grj_pkg::WID_W;

   function automatic logic [31:0] sat_mag(input logic [31:0] mag, input logic ov,
                                           input logic neg);
      logic big;
      big = ov | mag[31];
      if (neg) begin
         return big ? 32'h8000_0000 : (32'd0 - mag);
      end
      return big ? 32'h7FFF_FFFF : mag;
   endfunction

   logic signed [31:0] peak_height_ff;
   logic signed [31:0] peak_center_ff;
   logic [WW-1:0]      peak_width_ff;
   logic signed [31:0] baseline_ff;
   logic [WW-1:0]      weff_ff;
   logic signed [36:0] pen_ff;
   logic [31:0]        hmag_ff;
   logic               hneg_ff;
   logic               en;

   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_height_ff <= '0;
         peak_center_ff <= '0;
         peak_width_ff  <= 31'd327680;
         baseline_ff    <= '0;
      end else if (csr_wr_en) begin
         case (grj_pkg::reg_index_type'(csr_index))
            grj_pkg::REG_PEAK_HEIGHT: peak_height_ff <= csr_wdata;
            grj_pkg::REG_PEAK_CENTER: peak_center_ff <= csr_wdata;
            grj_pkg::REG_PEAK_WIDTH:  peak_width_ff  <= csr_wdata[WW-1:0];
            grj_pkg::REG_BASELINE:    baseline_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Values derived from the peak registers, refreshed every cycle.
   always_ff @(posedge clock) begin
      weff_ff <= (peak_width_ff == '0) ? WW'(1) : peak_width_ff;
      hneg_ff <= peak_height_ff < 0;
      hmag_ff <= (peak_height_ff < 0) ? (32'd0 - peak_height_ff) : peak_height_ff;
      pen_ff  <= (peak_height_ff <= 0) ?
                 -((37'(peak_height_ff) <<< 3) + (37'(peak_height_ff) <<< 1)) : '0;
   end

   // Front stage: offset from the center and the far-tail test.
   logic signed [32:0]     d_in;
   logic [32:0]            dmag_in;
   logic                   front_val_ff;
   logic [32:0]            dmag_ff;
   grj_pkg::side_ratio_type front_side_ff;
   grj_pkg::side_ratio_type front_side_in;

   always_comb begin
      d_in    = 33'(req_position) - 33'(peak_center_ff);
      dmag_in = d_in[32] ? (33'd0 - d_in) : d_in;
      front_side_in.measured   = req_measured;
      front_side_in.d_neg      = d_in[32];
      front_side_in.far        = {4'b0, dmag_in} >= {weff_ff, 6'b0};
      front_side_in.final_flag = req_final_flag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_val_ff <= 1'b0;
      end else if (en) begin
         front_val_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dmag_ff       <= dmag_in;
         front_side_ff <= front_side_in;
      end
   end

   // Ratio |D|/W in unsigned Q6.16.
   logic                    ratio_val;
   logic [RW-1:0]           ratio;
   grj_pkg::side_ratio_type ratio_side;

   grj_div #(
      .QW(RW),
      .DW(WW),
      .SW($bits(grj_pkg::side_ratio_type))
   ) u_div_ratio (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (front_val_ff),
      .in_rem   ({4'b0, dmag_ff[32:6]}),
      .in_num   ({dmag_ff[5:0], 16'b0}),
      .divisor  (weff_ff),
      .in_side  (front_side_ff),
      .out_valid(ratio_val),
      .out_quot (ratio),
      .out_side (ratio_side)
   );

   // Square of the ratio.
   logic                    sq_val_ff;
   logic [2*RW-1:0]         rr_ff;
   logic [RW-1:0]           r_sq_ff;
   grj_pkg::side_ratio_type sq_side_ff;
   grj_pkg::side_exp_type   exp_side_in;
   logic                    exp_zero;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_val_ff <= 1'b0;
      end else if (en) begin
         sq_val_ff <= ratio_val;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rr_ff      <= {{RW{1'b0}}, ratio} * {{RW{1'b0}}, ratio};
         r_sq_ff    <= ratio;
         sq_side_ff <= ratio_side;
      end
   end

   always_comb begin
      exp_zero                 = sq_side_ff.far || (rr_ff[2*RW-1:37] != '0);
      exp_side_in.ratio        = r_sq_ff;
      exp_side_in.sq           = rr_ff[36:16];
      exp_side_in.measured     = sq_side_ff.measured;
      exp_side_in.d_neg        = sq_side_ff.d_neg;
      exp_side_in.final_flag   = sq_side_ff.final_flag;
   end

   logic                     exp_val;
   logic [grj_pkg::E_W-1:0]  exp_e;
   grj_pkg::side_exp_type    exp_side;

   grj_exp #(
      .EXP_TABLE_BITS(EXP_TABLE_BITS),
      .SW($bits(grj_pkg::side_exp_type))
   ) u_exp (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (sq_val_ff),
      .in_zero  (exp_zero),
      .in_arg   (rr_ff[36:17]),
      .in_side  (exp_side_in),
      .out_valid(exp_val),
      .out_e    (exp_e),
      .out_side (exp_side)
   );

   // Peak term magnitude.
   logic                    g_val_ff;
   logic [31:0]             gmag_ff;
   logic [grj_pkg::E_W-1:0] g_e_ff;
   grj_pkg::side_exp_type   g_side_ff;
   logic [48:0]             gprod;

   assign gprod = {32'b0, exp_e} * {17'b0, hmag_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         g_val_ff <= 1'b0;
      end else if (en) begin
         g_val_ff <= exp_val;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         gmag_ff   <= gprod[47:16];
         g_e_ff    <= exp_e;
         g_side_ff <= exp_side;
      end
   end

   // Residual and the derivative numerators.
   logic signed [37:0]  res_in;
   logic signed [32:0]  gs;
   logic [31:0]         res_sat;
   logic                p_val_ff;
   logic [53:0]         pc_ff;
   logic [52:0]         pw_ff;
   grj_pkg::side_div_type p_side_ff;
   grj_pkg::side_div_type p_side_in;

   always_comb begin
      gs     = hneg_ff ? -$signed({1'b0, gmag_ff}) : $signed({1'b0, gmag_ff});
      res_in = 38'(gs) + 38'(baseline_ff) - 38'(signed'(g_side_ff.measured)) + 38'(pen_ff);
      if (res_in > 38'sd2147483647) begin
         res_sat = 32'h7FFF_FFFF;
      end else if (res_in < -38'sd2147483648) begin
         res_sat = 32'h8000_0000;
      end else begin
         res_sat = res_in[31:0];
      end
      p_side_in.residual   = res_sat;
      p_side_in.e          = g_e_ff;
      p_side_in.d_neg      = g_side_ff.d_neg;
      p_side_in.ov_c       = 1'b0;
      p_side_in.final_flag = g_side_ff.final_flag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_val_ff <= 1'b0;
      end else if (en) begin
         p_val_ff <= g_val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pc_ff     <= {22'b0, gmag_ff} * {32'b0, g_side_ff.ratio};
         pw_ff     <= {21'b0, gmag_ff} * {32'b0, g_side_ff.sq};
         p_side_ff <= p_side_in;
      end
   end

   // Quotients that do not fit in 32 bits are flagged and saturate at the end.
   grj_pkg::side_div_type dc_side_in;
   logic                  ov_w;

   always_comb begin
      dc_side_in      = p_side_ff;
      dc_side_in.ov_c = {9'b0, pc_ff[53:32]} >= weff_ff;
      ov_w            = {10'b0, pw_ff[52:32]} >= weff_ff;
   end

   logic                  dc_val;
   logic [QW_OUT-1:0]     dc_quot;
   grj_pkg::side_div_type dc_side;
   logic                  dw_val;
   logic [QW_OUT-1:0]     dw_quot;
   logic                  dw_ov;

   grj_div #(
      .QW(QW_OUT),
      .DW(WW),
      .SW($bits(grj_pkg::side_div_type))
   ) u_div_center (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (p_val_ff),
      .in_rem   ({9'b0, pc_ff[53:32]}),
      .in_num   (pc_ff[31:0]),
      .divisor  (weff_ff),
      .in_side  (dc_side_in),
      .out_valid(dc_val),
      .out_quot (dc_quot),
      .out_side (dc_side)
   );

   grj_div #(
      .QW(QW_OUT),
      .DW(WW),
      .SW(1)
   ) u_div_width (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (p_val_ff),
      .in_rem   ({10'b0, pw_ff[52:32]}),
      .in_num   (pw_ff[31:0]),
      .divisor  (weff_ff),
      .in_side  (ov_w),
      .out_valid(dw_val),
      .out_quot (dw_quot),
      .out_side (dw_ov)
   );

   // Result register.
   logic        rsp_valid_ff;
   logic [31:0] residual_ff;
   logic [16:0] d_height_ff;
   logic [31:0] d_center_ff;
   logic [31:0] d_width_ff;
   logic        final_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dc_val;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         residual_ff <= dc_side.residual;
         d_height_ff <= dc_side.e;
         d_center_ff <= sat_mag(dc_quot, dc_side.ov_c, hneg_ff ^ dc_side.d_neg);
         d_width_ff  <= sat_mag(dw_quot, dw_ov, hneg_ff);
         final_ff    <= dc_side.final_flag;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_residual  = residual_ff;
   assign rsp_d_height  = d_height_ff;
   assign rsp_d_center  = d_center_ff;
   assign rsp_d_width   = d_width_ff;
   assign rsp_final_out = final_ff;

   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      dc_val == dw_val)
      else $error("derivative dividers out of step");

   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow result stall");

   a_height_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_d_height <= 17'd65536)
      else $error("exponential term above one");

   a_tail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_d_height == '0) |-> (rsp_d_center == '0 && rsp_d_width == '0))
      else $error("nonzero derivative with zero exponential term");

endmodule

`default_nettype wire
